// File: rtl/core/bemp_pkg.sv
// Shared constants, codes and types of the big-endian memory port.
`default_nettype none
package bemp_pkg;

  localparam int MEM_WORDS   = 65536;
  localparam int STORE_BYTES = MEM_WORDS * 4;
  localparam int WIDX_W      = $clog2(MEM_WORDS);
  localparam int EVEN_DEPTH  = (MEM_WORDS + 1) / 2;
  localparam int ODD_DEPTH   = MEM_WORDS / 2;
  localparam int EVEN_AW     = $clog2(EVEN_DEPTH);
  localparam int ODD_AW      = $clog2(ODD_DEPTH);

  localparam int CFG_W       = 19;
  localparam int LIMIT_RESET = 262144;
  localparam int LIM_W       = $clog2(STORE_BYTES + 1);
  localparam int EL_W        = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam int EFF_RESET   = (LIMIT_RESET < STORE_BYTES) ? LIMIT_RESET : STORE_BYTES;

  localparam logic       FUNC_WRITE = 1'b1;
  localparam logic [1:0] SZ_BYTE    = 2'd0;
  localparam logic [1:0] SZ_HALF    = 2'd1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IO       = 2'd1,
    ST_ODD_HALF = 2'd2
  } status_t;

  // One decoded access: the two-word window starting at the word of the
  // first byte, with one enable per window byte (byte 0 most significant).
  typedef struct packed {
    logic               is_write;
    logic [1:0]         offset;
    logic [2:0]         nbytes;
    logic               w_odd;
    logic [7:0]         mask;
    status_t            status;
    logic [31:0]        wval;
    logic [EVEN_AW-1:0] even_addr;
    logic [ODD_AW-1:0]  odd_addr;
  } req_t;

  typedef struct packed {
    logic        even_we;
    logic [31:0] even_wd;
    logic        odd_we;
    logic [31:0] odd_wd;
  } bank_wr_t;

endpackage
`default_nettype wire

// File: rtl/core/big_endian_unaligned_memory_port.sv
// Big-endian byte/halfword/word memory port with unaligned access over two word banks.
// A taken word is staged over the bank read; the result and done strobe are registered from it.
// The port takes no new word while busy with the read-modify-write of the bank RAMs
//   (read in the accept cycle, merge and write back in the next).
// The receiver cannot stall: done is high for exactly one cycle per accepted word.
// Reset (rst, synchronous) clears the pipeline and sets the limit; RAM contents stay undefined.
`default_nettype none
module big_endian_unaligned_memory_port (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] byte_address,
  input  wire logic [31:0] write_value,
  output logic             done,
  output logic [31:0]      read_value,
  output logic [1:0]       status,
  input  wire logic        limit_we,
  input  wire logic [18:0] limit_data
);
  import bemp_pkg::*;

  // Effective limit: the written value clipped to the size of the store.
  logic [EL_W-1:0] limit;
  logic [EL_W-1:0] limit_ext;

  // Decoded request and the stage that holds it across the RAM read.
  req_t     req;
  req_t     stage;
  logic     stage_valid;
  logic     accept;

  logic [EVEN_AW-1:0] even_addr;
  logic [ODD_AW-1:0]  odd_addr;
  logic [31:0]        even_q;
  logic [31:0]        odd_q;
  logic [31:0]        rval;
  bank_wr_t           wr;

  assign accept    = start && !busy;
  assign busy      = stage_valid;
  assign limit_ext = EL_W'(limit_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= EL_W'(EFF_RESET);
    end else if (limit_we) begin
      limit <= (limit_ext < EL_W'(STORE_BYTES)) ? limit_ext : EL_W'(STORE_BYTES);
    end
  end

  bemp_decode u_decode (
    .func         (func),
    .access_size  (access_size),
    .byte_address (byte_address),
    .write_value  (write_value),
    .limit        (limit),
    .req          (req)
  );

  // Hold the request while the banks answer; the interlock on busy keeps the
  // write-back and the next read from meeting on the same entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= req;
    end
  end

  // Read at the incoming address, write back at the held one.
  assign even_addr = stage_valid ? stage.even_addr : req.even_addr;
  assign odd_addr  = stage_valid ? stage.odd_addr  : req.odd_addr;

  bemp_ram #(.WIDTH(32), .DEPTH(EVEN_DEPTH)) u_even_bank (
    .clk  (clk),
    .we   (stage_valid && wr.even_we),
    .addr (even_addr),
    .wd   (wr.even_wd),
    .rd   (even_q)
  );

  bemp_ram #(.WIDTH(32), .DEPTH(ODD_DEPTH)) u_odd_bank (
    .clk  (clk),
    .we   (stage_valid && wr.odd_we),
    .addr (odd_addr),
    .wd   (wr.odd_wd),
    .rd   (odd_q)
  );

  bemp_merge u_merge (
    .req    (stage),
    .even_q (even_q),
    .odd_q  (odd_q),
    .rval   (rval),
    .wr     (wr)
  );

  // Register the result and the done strobe from the held stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      read_value <= rval;
      status     <= stage.status;
    end
  end

  a_done_follows_stage : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stage_valid))
    else $error("result strobe without a word in flight");

  a_accept_blocks : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !accept)
    else $error("second word taken during read-modify-write");

  a_fail_reads_zero : assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (read_value == 32'h0))
    else $error("failed access returned data");

  a_write_only_on_store : assert property (@(posedge clk) disable iff (rst)
    (stage_valid && (wr.even_we || wr.odd_we)) |-> (stage.is_write && stage.status == ST_DONE))
    else $error("bank written by a read or a failed access");

endmodule
`default_nettype wire

// File: rtl/core/bemp_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module bemp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wd,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end

endmodule
`default_nettype wire

// File: rtl/core/bemp_decode.sv
// Request decode: status, byte enables of the window and bank addresses.
`default_nettype none
module bemp_decode (
  input  wire logic                  func,
  input  wire logic [1:0]            access_size,
  input  wire logic [31:0]           byte_address,
  input  wire logic [31:0]           write_value,
  input  wire logic [bemp_pkg::EL_W-1:0] limit,
  output bemp_pkg::req_t             req
);
  import bemp_pkg::*;

  logic [31:0]       lim32;
  logic [31:0]       base;
  logic [2:0]        nb;
  logic [3:0]        last;
  logic [WIDX_W-1:0] widx;
  logic [WIDX_W-1:0] widx_up;
  status_t           st;
  logic [32:0]       byte_addr_k;
  logic [7:0]        mask;

  always_comb begin
    lim32 = 32'(limit);
    base  = {byte_address[31:2], 2'b00};
    unique case (access_size)
      SZ_BYTE: nb = 3'd1;
      SZ_HALF: nb = 3'd2;
      default: nb = 3'd4;
    endcase
    last = {2'b00, byte_address[1:0]} + {1'b0, nb};

    priority if (func != FUNC_WRITE && access_size == SZ_HALF && byte_address[0]) begin
      st = ST_ODD_HALF;
    end else if (byte_address >= lim32) begin
      st = ST_IO;
    end else begin
      st = ST_DONE;
    end

    for (int k = 0; k < 8; k++) begin
      byte_addr_k = {1'b0, base} + 33'(k);
      mask[k] = (st == ST_DONE)
             && (4'(k) >= {2'b00, byte_address[1:0]})
             && (4'(k) < last)
             && (byte_addr_k < {1'b0, lim32});
    end

    widx    = byte_address[WIDX_W+1:2];
    widx_up = (widx >> 1) + WIDX_W'(1);

    req.is_write  = (func == FUNC_WRITE);
    req.offset    = byte_address[1:0];
    req.nbytes    = nb;
    req.w_odd     = widx[0];
    req.mask      = mask;
    req.status    = st;
    req.wval      = write_value;
    req.even_addr = widx[0] ? EVEN_AW'(widx_up) : EVEN_AW'(widx >> 1);
    req.odd_addr  = ODD_AW'(widx >> 1);
  end

endmodule
`default_nettype wire

// File: rtl/core/bemp_merge.sv
// Byte extraction for reads and byte merge for read-modify-write.
`default_nettype none
module bemp_merge (
  input  wire bemp_pkg::req_t   req,
  input  wire logic [31:0]      even_q,
  input  wire logic [31:0]      odd_q,
  output logic [31:0]           rval,
  output bemp_pkg::bank_wr_t    wr
);
  import bemp_pkg::*;

  logic [63:0] win;
  logic [63:0] masked;
  logic [63:0] aligned;
  logic [63:0] placed;
  logic [63:0] merged;
  logic [31:0] left;
  logic [5:0]  tail_sh;
  logic        we_first;
  logic        we_second;

  always_comb begin
    // first word of the window is the word of the first byte
    win     = req.w_odd ? {odd_q, even_q} : {even_q, odd_q};
    tail_sh = {3'd4 - req.nbytes, 3'b000};

    for (int k = 0; k < 8; k++) begin
      masked[63-8*k -: 8] = req.mask[k] ? win[63-8*k -: 8] : 8'h00;
    end
    aligned = masked << {req.offset, 3'b000};
    rval    = req.is_write ? 32'h0 : (aligned[63:32] >> tail_sh);

    left   = req.wval << tail_sh;
    placed = {left, 32'h0} >> {req.offset, 3'b000};
    for (int k = 0; k < 8; k++) begin
      merged[63-8*k -: 8] = req.mask[k] ? placed[63-8*k -: 8] : win[63-8*k -: 8];
    end

    we_first  = req.is_write && (|req.mask[3:0]);
    we_second = req.is_write && (|req.mask[7:4]);

    wr.even_we = req.w_odd ? we_second : we_first;
    wr.even_wd = req.w_odd ? merged[31:0] : merged[63:32];
    wr.odd_we  = req.w_odd ? we_first : we_second;
    wr.odd_wd  = req.w_odd ? merged[63:32] : merged[31:0];
  end

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench of the big-endian unaligned memory port: shadow store and predictor.
module tb;
  import bemp_pkg::*;

  localparam logic       FUNC_READ = 1'b0;
  localparam logic [1:0] SZ_WORD   = 2'd2;
  localparam logic [1:0] SZ_WIDE   = 2'd3;  // spare size code, behaves as a word
  localparam int         CLK_HALF  = 6;
  localparam int         N_DIR     = 24;
  localparam int         RUN_LIMIT = 200000;  // cycles, far beyond the slowest correct run

  // What one access should hand back.
  typedef struct packed {
    logic [31:0] rval;
    status_t     status;
  } access_res_t;

  // One row of the directed table; want_* only counts where typed is set.
  typedef struct packed {
    logic        is_wr;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        typed;
    logic [31:0] want_rval;
    status_t     want_status;
  } dir_row_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic        func         = 1'b0;
  logic [1:0]  access_size  = 2'd0;
  logic [31:0] byte_address = 32'd0;
  logic [31:0] write_value  = 32'd0;
  logic        limit_we     = 1'b0;
  logic [18:0] limit_data   = 19'd0;
  logic        busy;
  logic        done;
  logic [31:0] read_value;
  logic [1:0]  status;

  big_endian_unaligned_memory_port dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .access_size  (access_size),
    .byte_address (byte_address),
    .write_value  (write_value),
    .done         (done),
    .read_value   (read_value),
    .status       (status),
    .limit_we     (limit_we),
    .limit_data   (limit_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow of the store, one entry per byte, with a flag for bytes ever written.
  // The RAM powers up undefined, so a read may only touch flagged bytes.
  logic [7:0]  shadow_bytes [0:STORE_BYTES-1];
  bit          byte_written [0:STORE_BYTES-1];
  logic [18:0] limit_reg;
  access_res_t pending_q [$];
  access_res_t oldest;
  int          errors = 0;

  // Directed table: hand-typed answers only for writes, I/O hits and odd halfword reads.
  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{FUNC_WRITE, SZ_WORD, 32'h0000_0000, 32'h0123_4567, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_WORD, 32'h0000_0000, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_WRITE, SZ_WORD, 32'h0000_0005, 32'h89ab_cdef, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_WORD, 32'h0000_0005, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_WRITE, SZ_BYTE, 32'h0000_0004, 32'hffff_ff5a, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_WORD, 32'h0000_0003, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_WRITE, SZ_HALF, 32'h0000_0009, 32'h0000_beef, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_HALF, 32'h0000_0009, 32'h0,         1'b1, 32'h0, ST_ODD_HALF},
    '{FUNC_READ,  SZ_HALF, 32'h0000_0008, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_BYTE, 32'h0000_000a, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_WRITE, SZ_WIDE, 32'h0000_000c, 32'hcafe_f00d, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_WIDE, 32'h0000_000c, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_HALF, 32'hffff_ffff, 32'h0,         1'b1, 32'h0, ST_ODD_HALF},
    '{FUNC_READ,  SZ_WORD, 32'hffff_fffc, 32'h0,         1'b1, 32'h0, ST_IO},
    '{FUNC_WRITE, SZ_WORD, 32'h0004_0000, 32'hffff_ffff, 1'b1, 32'h0, ST_IO},
    '{FUNC_WRITE, SZ_WORD, 32'h0003_fffe, 32'ha1b2_c3d4, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_WORD, 32'h0003_fffe, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_WRITE, SZ_HALF, 32'h0003_ffff, 32'h0000_7788, 1'b1, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_BYTE, 32'h0003_ffff, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_HALF, 32'h0003_fffe, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_WRITE, SZ_BYTE, 32'h8000_0000, 32'h0,         1'b1, 32'h0, ST_IO},
    '{FUNC_READ,  SZ_BYTE, 32'h0000_0000, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_HALF, 32'h0000_0000, 32'h0,         1'b0, 32'h0, ST_DONE},
    '{FUNC_READ,  SZ_BYTE, 32'h0004_0000, 32'h0,         1'b1, 32'h0, ST_IO}
  };

  // The limit never reaches past the end of the store.
  function automatic int unsigned eff_limit();
    return (limit_reg < STORE_BYTES) ? limit_reg : STORE_BYTES;
  endfunction

  function automatic int unsigned byte_count(input logic [1:0] sz);
    return (sz == SZ_BYTE) ? 1 : ((sz == SZ_HALF) ? 2 : 4);
  endfunction

  // Apply one access to the shadow store and work out its result.
  task automatic mem_access(input logic f, input logic [1:0] sz, input logic [31:0] addr,
                            input logic [31:0] wdata, output access_res_t res);
    int unsigned lim;
    int unsigned n;
    int unsigned a;
    lim = eff_limit();
    n = byte_count(sz);
    res.rval = 32'd0;
    res.status = ST_DONE;
    if (f == FUNC_READ && sz == SZ_HALF && addr[0]) begin
      res.status = ST_ODD_HALF;
    end else if (addr >= lim) begin
      res.status = ST_IO;
    end else begin
      // first byte is the most significant; bytes past the limit are dropped
      for (int i = 0; i < n; i++) begin
        a = addr + i;
        if (f == FUNC_WRITE) begin
          if (a < lim) begin
            shadow_bytes[a] = 8'(wdata >> (8 * (n - 1 - i)));
            byte_written[a] = 1'b1;
          end
        end else begin
          res.rval = {res.rval[23:0], (a < lim) ? shadow_bytes[a] : 8'h00};
        end
      end
    end
  endtask

  // A read is fit to send if every byte it would fetch has been written.
  function automatic bit read_is_safe(input logic [1:0] sz, input logic [31:0] addr);
    int unsigned lim;
    int unsigned a;
    lim = eff_limit();
    if (addr >= lim || (sz == SZ_HALF && addr[0]))
      return 1'b1;
    for (int i = 0; i < byte_count(sz); i++) begin
      a = addr + i;
      if (a < lim && !byte_written[a])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Aim mostly at a few hot windows so reads find written bytes and hit the edges.
  function automatic logic [31:0] pick_address();
    int unsigned lim;
    int unsigned base;
    lim = eff_limit();
    base = (lim > 24) ? lim - 24 : 0;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 63);
      3, 4, 5: return base + $urandom_range(0, 32);
      6:       return STORE_BYTES - 32 + $urandom_range(0, 40);
      7:       return $urandom;
      default: return $urandom_range(0, STORE_BYTES - 1);
    endcase
  endfunction

  function automatic logic [1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    return (r == 0) ? SZ_WIDE : 2'(r % 3);
  endfunction

  // Offer one word and hold it until taken; predict at the accepting edge.
  task automatic send_access(input logic f, input logic [1:0] sz, input logic [31:0] addr,
                             input logic [31:0] wdata, input bit typed,
                             input access_res_t typed_res);
    access_res_t res;
    @(negedge clk);
    start        <= 1'b1;
    func         <= f;
    access_size  <= sz;
    byte_address <= addr;
    write_value  <= wdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    mem_access(f, sz, addr, wdata, res);
    pending_q.push_back(typed ? typed_res : res);
  endtask

  // Drop start and scramble the fields for an idle spell; n gives its length.
  task automatic idle_cycles(input int n);
    @(negedge clk);
    start        <= 1'b0;
    func         <= 1'($urandom);
    access_size  <= 2'($urandom);
    byte_address <= $urandom;
    write_value  <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending, wait for every outstanding result, then let the pipe settle.
  task automatic drain(input int settle);
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0 && guard < 100) begin
      @(posedge clk);
      guard++;
    end
    if (pending_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_q.size());
      errors++;
      pending_q.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  // Write the limit only with the port idle.
  task automatic set_limit(input logic [18:0] value);
    drain(4);
    @(negedge clk);
    limit_we   <= 1'b1;
    limit_data <= value;
    @(negedge clk);
    limit_we   <= 1'b0;
    limit_data <= 19'($urandom);
    limit_reg = value;
  endtask

  // Random accesses; unsafe reads become writes. Idle in bursts unless calm.
  task automatic random_phase(input int count, input bit calm);
    logic       f;
    logic [1:0] sz;
    logic [31:0] addr;
    bit         noisy;
    noisy = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 25 == 0)
        noisy = !calm && ($urandom_range(0, 2) != 0);
      f = 1'($urandom_range(0, 1));
      sz = pick_size();
      addr = pick_address();
      if (f == FUNC_READ && !read_is_safe(sz, addr))
        f = FUNC_WRITE;
      send_access(f, sz, addr, $urandom, 1'b0, '0);
      if (noisy && $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(1, 10));
    end
  endtask

  // Check every strobed word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got read_value %h status %0d",
                 $time, read_value, status);
        errors++;
      end else begin
        oldest = pending_q.pop_front();
        if (read_value !== oldest.rval) begin
          $display("%0t: read_value expected %h, got %h", $time, oldest.rval, read_value);
          errors++;
        end
        if (status !== oldest.status) begin
          $display("%0t: status expected %0d, got %0d", $time, oldest.status, status);
          errors++;
        end
      end
    end
  end

  initial begin
    #(2 * CLK_HALF * RUN_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    dir_row_t    row;
    access_res_t row_res;
    limit_reg = 19'(LIMIT_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit: extremes, unaligned merges, spills off the store end.
    for (int r = 0; r < N_DIR; r++) begin
      row = dir_rows[r];
      row_res.rval = row.want_rval;
      row_res.status = row.want_status;
      send_access(row.is_wr, row.size, row.addr, row.wdata, row.typed, row_res);
    end

    // Random phases over several limits: none, odd and tiny, odd mid-range, beyond the store, one short, random, reset.
    set_limit(19'd0);
    random_phase(40, 1'b0);
    set_limit(19'd7);
    random_phase(100, 1'b0);
    set_limit(19'd1001);
    random_phase(120, 1'b0);
    set_limit(19'h7ffff);
    random_phase(120, 1'b0);
    set_limit(19'(STORE_BYTES - 1));
    random_phase(120, 1'b0);
    set_limit(19'(16 + $urandom_range(0, 2047)));
    random_phase(120, 1'b0);
    set_limit(19'(LIMIT_RESET));
    random_phase(150, 1'b0);
    // hold off until the port is empty, then finish with no idling
    drain(0);
    random_phase(150, 1'b1);
    drain(4);

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
